[design/aes128_pkg.sv]
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] blk_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  // stage sideband: valid and direction travel with the state
  typedef struct packed {
    logic vld;
    op_t  op;
  } ctl_t;

  function automatic byte_t sbox_fwd(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t sbox_inv(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t rcon(input logic [3:0] rnd);
    byte_t r;
    case (rnd)
      4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
      4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
      4'd9: r = 8'h1b; 4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic byte_t get_b(input blk_t s, input int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic blk_t next_rkey(input blk_t k, input logic [3:0] rnd);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox_fwd(w3[23:16]) ^ rcon(rnd), sbox_fwd(w3[15:8]),
         sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

[design/aes128_round.sv]
`timescale 1ns / 1ps
// One pipeline stage: one cipher round in either direction, key given.
// Forward: sub, shift, mix (unless last), add key.
// Inverse: inv shift, inv sub, add key, inv mix (unless last).
module aes128_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  aes128_pkg::ctl_t      ctl_in,
  input  aes128_pkg::blk_t      st_in,
  input  aes128_pkg::blk_t      rk_fwd,
  input  aes128_pkg::blk_t      rk_inv,
  output aes128_pkg::ctl_t      ctl_out,
  output aes128_pkg::blk_t      st_out
);

  aes128_pkg::ctl_t ctl_r;
  aes128_pkg::blk_t st_r, st_nxt;

  always_comb begin
    aes128_pkg::byte_t sf [16];
    aes128_pkg::byte_t si [16];
    aes128_pkg::byte_t tf [16];
    aes128_pkg::byte_t ti [16];
    aes128_pkg::byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
    aes128_pkg::blk_t fwd, inv;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        // left rotate for forward, right rotate for inverse
        sf[r + 4*c] = aes128_pkg::sbox_fwd(
          aes128_pkg::get_b(st_in, r + 4*((c + r) % 4)));
        si[r + 4*c] = aes128_pkg::sbox_inv(
          aes128_pkg::get_b(st_in, r + 4*((c + 4 - r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      // forward mix
      a0 = sf[4*c]; a1 = sf[4*c+1]; a2 = sf[4*c+2]; a3 = sf[4*c+3];
      x0 = aes128_pkg::xtime(a0); x1 = aes128_pkg::xtime(a1);
      x2 = aes128_pkg::xtime(a2); x3 = aes128_pkg::xtime(a3);
      tf[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      tf[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      tf[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      tf[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
    end
    for (int i = 0; i < 16; i++) begin
      fwd[127 - 8*i -: 8] = (LastRound ? sf[i] : tf[i]) ^ aes128_pkg::get_b(rk_fwd, i);
      si[i] = si[i] ^ aes128_pkg::get_b(rk_inv, i);
    end
    for (int c = 0; c < 4; c++) begin
      // inverse mix: pre-multiply by {4,5} then forward mix
      a0 = si[4*c]; a1 = si[4*c+1]; a2 = si[4*c+2]; a3 = si[4*c+3];
      y0 = aes128_pkg::xtime(aes128_pkg::xtime(a0 ^ a2));
      y1 = aes128_pkg::xtime(aes128_pkg::xtime(a1 ^ a3));
      a0 = a0 ^ y0; a1 = a1 ^ y1; a2 = a2 ^ y0; a3 = a3 ^ y1;
      x0 = aes128_pkg::xtime(a0); x1 = aes128_pkg::xtime(a1);
      x2 = aes128_pkg::xtime(a2); x3 = aes128_pkg::xtime(a3);
      ti[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      ti[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      ti[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      ti[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
    end
    for (int i = 0; i < 16; i++) begin
      inv[127 - 8*i -: 8] = LastRound ? si[i] : ti[i];
    end
    st_nxt = (ctl_in.op == aes128_pkg::OP_DECRYPT) ? inv : fwd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{vld: 1'b0, op: aes128_pkg::OP_ENCRYPT};
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign st_out  = st_r;

endmodule

[design/aes128_block_cipher_unit.sv]
`timescale 1ns / 1ps
// Channel | Ports                                        | Accepted when
// in      | in_valid in_ready in_opcode in_block_high/low | in_valid & in_ready
// out     | out_valid out_ready out_high out_low         | out_valid & out_ready
// cfg     | cfg_valid cfg_ready cfg_index cfg_data       | cfg_valid & cfg_ready
//
// Eleven register stages (initial key add, ten rounds), one item per cycle while
// in_ready is high. Round keys are expanded from the key registers into a table
// of eleven registers; after reset or any key write the table refills one key at
// a time, in_ready low meanwhile and while cfg_valid is high. Reset is synchronous
// and clears the keys. A low out_ready with out_valid high freezes the whole pipe.
module aes128_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned NR = aes128_pkg::NumRounds;

  logic [63:0] key_hi_r, key_lo_r;
  aes128_pkg::blk_t rk_r [NR+1];
  logic [3:0] exp_cnt_r;
  logic       adv;

  aes128_pkg::ctl_t ctl [1:NR+1];
  aes128_pkg::blk_t st  [1:NR+1];

  assign cfg_ready = 1'b1;

  // count from zero: rk_r[0] takes the new key in the cycle after the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r  <= '0;
      key_lo_r  <= '0;
      exp_cnt_r <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == aes128_pkg::REG_KEY_HIGH) key_hi_r <= cfg_data;
      else key_lo_r <= cfg_data;
      exp_cnt_r <= 4'd0;
    end else if (exp_cnt_r <= 4'(NR)) begin
      exp_cnt_r <= exp_cnt_r + 4'd1;
    end
  end

  // expand one round key a cycle, restarting on any key write
  always_ff @(posedge clk) begin
    rk_r[0] <= {key_hi_r, key_lo_r};
    for (int k = 1; k <= NR; k++) begin
      if (exp_cnt_r == 4'(k)) begin
        rk_r[k] <= aes128_pkg::next_rkey(rk_r[k-1], 4'(k));
      end
    end
  end

  // rk_r[0] is registered from the key regs, so ready waits until the count passes NR
  assign in_ready = adv && (exp_cnt_r > 4'(NR)) && !cfg_valid;
  assign adv      = out_ready || !ctl[NR+1].vld;

  aes128_pkg::ctl_t ctl0_r;
  aes128_pkg::blk_t st0_r;
  aes128_pkg::blk_t blk_in;
  assign blk_in = {in_block_high, in_block_low};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '{vld: 1'b0, op: aes128_pkg::OP_ENCRYPT};
    end else if (adv) begin
      ctl0_r <= '{vld: in_valid && in_ready, op: aes128_pkg::op_t'(in_opcode)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r <= blk_in ^ (in_opcode ? rk_r[NR] : rk_r[0]);
    end
  end

  assign ctl[1] = ctl0_r;
  assign st[1]  = st0_r;

  for (genvar g = 1; g <= NR; g++) begin : g_rnd
    aes128_round #(.LastRound(g == NR)) u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl_in  (ctl[g]),
      .st_in   (st[g]),
      .rk_fwd  (rk_r[g]),
      .rk_inv  (rk_r[NR-g]),
      .ctl_out (ctl[g+1]),
      .st_out  (st[g+1])
    );
  end

  assign out_valid = ctl[NR+1].vld;
  assign out_high  = st[NR+1][127:64];
  assign out_low   = st[NR+1][63:0];

endmodule

[verif/aes128_cipher_checker.sv]
`timescale 1ns / 1ps
module aes128_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_high,
  input  logic [63:0] out_low,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending_blocks
);

  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];
  logic [63:0] key_hi, key_lo;
  logic [127:0] expected_blocks [$];

  // build the substitution tables from the field inverse and the affine map
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      s = 8'h63;
      for (int i = 0; i < 8; i++)
        s[i] = s[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
      fwd_tab[a] = s;
      inv_tab[s] = a[7:0];
    end
  end

  function automatic logic [127:0] aes_cipher(input logic dir, input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] rc, first;
    logic [127:0] key, res;
    key = {key_hi, key_lo};
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8];
    end
    rc = 8'h01;
    for (int w = 4; w < 44; w++) begin
      for (int k = 0; k < 4; k++) t[k] = rk[4*(w-1)+k];
      if (w % 4 == 0) begin
        first = t[0];
        t[0] = fwd_tab[t[1]] ^ rc;
        t[1] = fwd_tab[t[2]];
        t[2] = fwd_tab[t[3]];
        t[3] = fwd_tab[first];
        rc = gmul(rc, 8'h02);
      end
      for (int k = 0; k < 4; k++) rk[4*w+k] = rk[4*(w-4)+k] ^ t[k];
    end
    if (dir == aes128_pkg::OP_ENCRYPT) begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) st[i] = fwd_tab[st[i]];
        for (int i = 0; i < 16; i++) tmp[i] = st[i%4 + 4*((i/4 + i%4) % 4)];
        st = tmp;
        if (r != 10)
          for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
              st[4*c+q] = gmul(8'h02, tmp[4*c+q]) ^ gmul(8'h03, tmp[4*c+(q+1)%4])
                        ^ tmp[4*c+(q+2)%4] ^ tmp[4*c+(q+3)%4];
        for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[160+i];
      for (int r = 10; r > 0; r--) begin
        for (int i = 0; i < 16; i++) tmp[i%4 + 4*((i/4 + i%4) % 4)] = st[i];
        for (int i = 0; i < 16; i++) st[i] = inv_tab[tmp[i]] ^ rk[16*(r-1)+i];
        tmp = st;
        if (r != 1)
          for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
              st[4*c+q] = gmul(8'h0e, tmp[4*c+q]) ^ gmul(8'h0b, tmp[4*c+(q+1)%4])
                        ^ gmul(8'h0d, tmp[4*c+(q+2)%4]) ^ gmul(8'h09, tmp[4*c+(q+3)%4]);
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_blocks = expected_blocks.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      key_hi <= '0;
      key_lo <= '0;
      expected_blocks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("unexpected result %h %h at %0t", out_high, out_low, $realtime);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_high !== want[127:64]) report_mismatch("out_high", out_high, want[127:64]);
          if (out_low !== want[63:0]) report_mismatch("out_low", out_low, want[63:0]);
        end
      end
      if (in_valid && in_ready)
        expected_blocks.push_back(aes_cipher(in_opcode, {in_block_high, in_block_low}));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == aes128_pkg::REG_KEY_HIGH) key_hi <= cfg_data;
        else key_lo <= cfg_data;
      end
    end
  end

endmodule

[verif/aes128_block_cipher_unit_test.sv]
`timescale 1ns / 1ps
module aes128_block_cipher_unit_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_high, out_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending_blocks;
  int          cycle_count = 0;
  logic        drain_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aes128_block_cipher_unit u_dut (.*);

  aes128_cipher_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("aes128_block_cipher_unit_test NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, with an unstalled stretch in drain mode
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = drain_mode ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // leaves cfg_valid high so writes can follow back to back; drop it after
  task automatic write_key(input aes128_pkg::reg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
  endtask

  task automatic send_block(input aes128_pkg::op_t op, input logic [63:0] hi,
                            input logic [63:0] lo, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (!no_gap && $urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_block_high <= hi;
    in_block_low <= lo;
    @(posedge clk iff in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk iff pending_blocks == 0);
    repeat (15) @(posedge clk);
  endtask

  initial begin
    logic [63:0] keys [6][2];
    logic [63:0] pat [4];
    logic [63:0] h, l;
    keys[0] = '{64'h0, 64'h0};
    keys[1] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f};
    keys[2] = '{64'hffffffffffffffff, 64'hffffffffffffffff};
    keys[3] = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c};
    keys[4] = '{64'h0, 64'hffffffffffffffff};
    keys[5] = '{64'hffffffffffffffff, 64'h0};
    pat = '{64'h0, 64'hffffffffffffffff, 64'h0011223344556677, 64'h8899aabbccddeeff};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key first, then the known test key, all extremes of the block
    for (int p = 0; p < 4; p++)
      for (int q = 0; q < 4; q++)
        send_block(aes128_pkg::op_t'((p + q) % 2), pat[p], pat[q], 1'b0);
    wait_idle();
    write_key(aes128_pkg::REG_KEY_HIGH, keys[1][0]);
    write_key(aes128_pkg::REG_KEY_LOW, keys[1][1]);
    cfg_valid <= 1'b0;
    send_block(aes128_pkg::OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(aes128_pkg::OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    send_block(aes128_pkg::OP_DECRYPT, 64'h0, 64'h0, 1'b0);
    send_block(aes128_pkg::OP_ENCRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0);
    wait_idle();

    for (int ph = 2; ph < 12; ph++) begin
      if (ph < 6) begin
        write_key(aes128_pkg::REG_KEY_HIGH, keys[ph][0]);
        write_key(aes128_pkg::REG_KEY_LOW, keys[ph][1]);
      end else begin
        write_key(aes128_pkg::REG_KEY_HIGH, rand64());
        if ($urandom_range(0, 1)) write_key(aes128_pkg::REG_KEY_LOW, rand64());
      end
      cfg_valid <= 1'b0;
      drain_mode <= (ph == 7);
      for (int n = 0; n < 160; n++) begin
        h = rand64();
        l = rand64();
        send_block(aes128_pkg::op_t'($urandom_range(0, 1)), h, l, ph == 7 || ph == 9);
        if (n == 80 && ph == 4) wait_idle();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("aes128_block_cipher_unit_test OK");
    end else begin
      $display("aes128_block_cipher_unit_test NOT OK");
    end
    $finish;
  end

endmodule

[aes128_block_cipher_unit.f]
design/aes128_pkg.sv
design/aes128_round.sv
design/aes128_block_cipher_unit.sv
verif/aes128_cipher_checker.sv
verif/aes128_block_cipher_unit_test.sv
